// ===== hdl/srtf_pkg.sv =====
package srtf_pkg;

	// fixed widths of the request and result ports
	localparam int ID_PORT_W    = 8;
	localparam int BURST_PORT_W = 16;
	localparam int COUNT_PORT_W = 5;
	localparam int TIME_W       = 32;

	typedef enum logic {
		OP_ARRIVAL = 1'b0,
		OP_TICK    = 1'b1
	} srtf_op_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic latch;   // capture request fields
		logic exec;    // apply the captured request to the queue
	} srtf_cmd_t;

endpackage

// ===== hdl/srtf_ctrl.sv =====
module srtf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output logic                done,
	output srtf_pkg::srtf_cmd_t cmd
);
	import srtf_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					done_q <= 1'b0;
					if (start) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign cmd.latch = start && (state_q == ST_IDLE);
	assign cmd.exec  = (state_q == ST_EXEC);

endmodule

// ===== hdl/srtf_dp.sv =====
module srtf_dp #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS     = 8,
	parameter int TIME_BITS   = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  srtf_pkg::srtf_cmd_t                 cmd,
	input  logic                                operation,
	input  logic [srtf_pkg::ID_PORT_W-1:0]      task_id,
	input  logic [srtf_pkg::BURST_PORT_W-1:0]   burst_time,
	output logic                                rejected,
	output logic                                completed,
	output logic [srtf_pkg::ID_PORT_W-1:0]      completed_id,
	output logic [srtf_pkg::TIME_W-1:0]         finish_time,
	output logic                                running_valid,
	output logic [srtf_pkg::ID_PORT_W-1:0]      running_id,
	output logic [srtf_pkg::COUNT_PORT_W-1:0]   queue_count
);
	import srtf_pkg::*;

	localparam int CW  = $clog2(QUEUE_DEPTH + 1);
	localparam int IXW = (ID_BITS > ID_PORT_W) ? ID_BITS : ID_PORT_W;
	localparam int TXW = (TIME_BITS > BURST_PORT_W) ? TIME_BITS : BURST_PORT_W;
	localparam int QXW = (CW > COUNT_PORT_W) ? CW : COUNT_PORT_W;

	// captured request
	srtf_op_t             op_q;
	logic [ID_BITS-1:0]   new_id_q;
	logic [TIME_BITS-1:0] new_rem_q;

	// queue cells, sorted by remaining time, head at index 0
	logic [ID_BITS-1:0]   id_q  [QUEUE_DEPTH];
	logic [TIME_BITS-1:0] rem_q [QUEUE_DEPTH];
	logic [CW-1:0]        count_q;
	logic [TIME_W-1:0]    time_q;

	logic                 rejected_q;
	logic                 completed_q;
	logic [ID_PORT_W-1:0] completed_id_q;
	logic [TIME_W-1:0]    finish_time_q;

	logic [IXW-1:0] id_in_ext;
	logic [TXW-1:0] burst_in_ext;
	logic [IXW-1:0] head_id_ext;
	logic [QXW-1:0] count_ext;

	logic [QUEUE_DEPTH-1:0] ge;
	logic                   is_full;
	logic                   is_empty;
	logic                   refuse;
	logic                   head_last;
	logic                   do_ins;
	logic                   do_pop;
	logic                   do_dec;

	assign id_in_ext    = IXW'(task_id);
	assign burst_in_ext = TXW'(burst_time);
	assign head_id_ext  = IXW'(id_q[0]);
	assign count_ext    = QXW'(count_q);

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q      <= srtf_op_t'(operation);
			new_id_q  <= id_in_ext[ID_BITS-1:0];
			new_rem_q <= burst_in_ext[TIME_BITS-1:0];
		end
	end

	// the first cell that is empty or holds an equal or longer time takes the new task
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			ge[i] = (CW'(i) >= count_q) || (rem_q[i] >= new_rem_q);
		end
	end

	assign is_full   = (count_q == CW'(QUEUE_DEPTH));
	assign is_empty  = (count_q == '0);
	assign refuse    = is_full || (new_rem_q == '0);
	assign head_last = (rem_q[0] <= TIME_BITS'(1));
	assign do_ins    = cmd.exec && (op_q == OP_ARRIVAL) && !refuse;
	assign do_pop    = cmd.exec && (op_q == OP_TICK) && !is_empty && head_last;
	assign do_dec    = cmd.exec && (op_q == OP_TICK) && !is_empty && !head_last;

	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
		if (g == 0) begin : g_head
			always_ff @(posedge clk) begin
				if (do_ins && ge[0]) begin
					id_q[0]  <= new_id_q;
					rem_q[0] <= new_rem_q;
				end else if (do_pop) begin
					if (QUEUE_DEPTH > 1) begin
						id_q[0]  <= id_q[1];
						rem_q[0] <= rem_q[1];
					end
				end else if (do_dec) begin
					rem_q[0] <= rem_q[0] - TIME_BITS'(1);
				end
			end
		end else begin : g_body
			always_ff @(posedge clk) begin
				if (do_ins) begin
					if (ge[g-1]) begin
						id_q[g]  <= id_q[g-1];
						rem_q[g] <= rem_q[g-1];
					end else if (ge[g]) begin
						id_q[g]  <= new_id_q;
						rem_q[g] <= new_rem_q;
					end
				end else if (do_pop && (g < QUEUE_DEPTH - 1)) begin
					id_q[g]  <= id_q[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
					rem_q[g] <= rem_q[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			time_q  <= '0;
		end else if (cmd.exec) begin
			if (op_q == OP_TICK) begin
				time_q <= time_q + TIME_W'(1);
			end
			if (do_ins) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rejected_q     <= (op_q == OP_ARRIVAL) && refuse;
			completed_q    <= do_pop;
			completed_id_q <= do_pop ? head_id_ext[ID_PORT_W-1:0] : '0;
			finish_time_q  <= do_pop ? (time_q + TIME_W'(1)) : '0;
		end
	end

	assign rejected      = rejected_q;
	assign completed     = completed_q;
	assign completed_id  = completed_id_q;
	assign finish_time   = finish_time_q;
	assign running_valid = !is_empty;
	assign running_id    = is_empty ? '0 : head_id_ext[ID_PORT_W-1:0];
	assign queue_count   = count_ext[COUNT_PORT_W-1:0];

endmodule

// ===== hdl/srtf_ready_queue_scheduler_top.sv =====
// the accepting edge captures the request; the queue update, results and done strobe are registered together in exec
// a new request is taken only while the controller is idle, never while busy with the last one
// the receiver cannot stall; each result is valid in the done cycle and holds until the next request's update
// reset clears the task count, time counter and controller at once; no clearing pass,
// contents of queue cells beyond the count never reach an output
module srtf_ready_queue_scheduler_top #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS     = 8,
	parameter int TIME_BITS   = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	output logic                                done,
	input  logic                                operation,
	input  logic [srtf_pkg::ID_PORT_W-1:0]      task_id,
	input  logic [srtf_pkg::BURST_PORT_W-1:0]   burst_time,
	output logic                                rejected,
	output logic                                completed,
	output logic [srtf_pkg::ID_PORT_W-1:0]      completed_id,
	output logic [srtf_pkg::TIME_W-1:0]         finish_time,
	output logic                                running_valid,
	output logic [srtf_pkg::ID_PORT_W-1:0]      running_id,
	output logic [srtf_pkg::COUNT_PORT_W-1:0]   queue_count
);
	import srtf_pkg::*;

	// controller to datapath commands
	srtf_cmd_t cmd;

	// sequencer: idle -> exec, raises done together with the registered queue update
	srtf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// sorted cell queue with parallel compare-and-shift insert, head pop and
	// head decrement; results and head status come from registers
	srtf_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ID_BITS     (ID_BITS),
		.TIME_BITS   (TIME_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.operation     (operation),
		.task_id       (task_id),
		.burst_time    (burst_time),
		.rejected      (rejected),
		.completed     (completed),
		.completed_id  (completed_id),
		.finish_time   (finish_time),
		.running_valid (running_valid),
		.running_id    (running_id),
		.queue_count   (queue_count)
	);

endmodule
